>>> rtl/core/assert_macros.svh
// Assertion helpers for the keypad ID entry controller.
// All checks are sampled on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KIE_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("implication check failed");

// Next-cycle implication.
`define KIE_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/kie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kie_pkg
// Shared types and codes for the keypad ID entry controller.
// ----------------------------------------------------------------------------
package kie_pkg;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_CANCEL  = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_EXHAUST = 3'd4,
    ST_RETRY   = 3'd5,
    ST_IDLE    = 3'd6
  } status_t;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd10;
  localparam logic [3:0] KEY_HASH       = 4'd11;

  localparam logic [3:0] ATTEMPT_SAT = 4'd15;
  localparam logic [7:0] TIMER_SAT   = 8'd255;

  localparam logic [7:0] TIMEOUT_RST  = 8'd60;
  localparam logic [3:0] ATTEMPTS_RST = 4'd3;

  // configuration register indexes
  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_ATTEMPTS = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] key_code;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [9:0] id_value;
    logic [1:0] digits_entered;
    logic       confirming;
  } result_t;

endpackage

>>> rtl/core/kie_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kie_in_stage
// Input register: holds one event word until the core takes it.
// ----------------------------------------------------------------------------
module kie_in_stage import kie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_key_code,
  input  logic       adv,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall  = valid_r && !adv;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{func: in_func, key_code: in_key_code};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/core/kie_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kie_core
// Session state, configuration registers and the per-event update.
// ----------------------------------------------------------------------------
module kie_core import kie_pkg::*; #(
  parameter int MAX_DIGITS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       step,
  input  item_t      item,
  output result_t    result
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_DIGITS);

  logic [7:0]    timeout_r;
  logic [3:0]    max_att_r;

  logic          active_r, active_nxt;
  logic          confirm_r, confirm_nxt;
  logic [3:0]    store_r   [MAX_DIGITS];
  logic [3:0]    store_nxt [MAX_DIGITS];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    att_r, att_nxt;
  logic [7:0]    stimer_r, stimer_nxt;
  logic [7:0]    ctimer_r, ctimer_nxt;

  status_t       status;
  logic [9:0]    id_acc;
  logic [3:0]    shown;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      max_att_r <= ATTEMPTS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TIMEOUT:  timeout_r <= cfg_wdata;
        CFG_ATTEMPTS: max_att_r <= cfg_wdata[3:0];
        default:      ;
      endcase
    end
  end

  // decimal value of the full entry, kept mod 1024
  always_comb begin
    id_acc = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      id_acc = 10'(id_acc * 10'd10) + 10'(store_r[i]);
    end
  end

  always_comb begin
    active_nxt  = active_r;
    confirm_nxt = confirm_r;
    store_nxt   = store_r;
    cnt_nxt     = cnt_r;
    att_nxt     = att_r;
    stimer_nxt  = stimer_r;
    ctimer_nxt  = ctimer_r;
    status      = ST_BUSY;

    if (item.func == FUNC_START) begin
      for (int i = 0; i < MAX_DIGITS; i++) store_nxt[i] = '0;
      cnt_nxt     = '0;
      att_nxt     = '0;
      stimer_nxt  = '0;
      ctimer_nxt  = '0;
      confirm_nxt = 1'b0;
      active_nxt  = 1'b1;
    end else if (!active_r) begin
      status = ST_IDLE;
    end else if (item.func == FUNC_TICK) begin
      stimer_nxt = (stimer_r < TIMER_SAT) ? stimer_r + 8'd1 : TIMER_SAT;
      if (confirm_r) begin
        ctimer_nxt = (ctimer_r < TIMER_SAT) ? ctimer_r + 8'd1 : TIMER_SAT;
        if (ctimer_nxt >= timeout_r) status = ST_TIMEOUT;
      end else if (stimer_nxt >= timeout_r) begin
        status = ST_TIMEOUT;
      end
    end else if (item.func == FUNC_KEY) begin
      if (confirm_r) begin
        if (ctimer_r >= timeout_r) begin
          status = ST_TIMEOUT;
        end else if (item.key_code == KEY_STAR) begin
          status = ST_CANCEL;
        end else if (item.key_code == KEY_HASH) begin
          confirm_nxt = 1'b0;
          if (stimer_r >= timeout_r) status = ST_TIMEOUT;
        end
      end else if (stimer_r >= timeout_r) begin
        status = ST_TIMEOUT;
      end else if (item.key_code <= KEY_LAST_DIGIT) begin
        if (cnt_r < CNT_FULL) begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (cnt_r == CW'(i)) store_nxt[i] = item.key_code;
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end else if (item.key_code == KEY_STAR) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (cnt_nxt == CW'(i)) store_nxt[i] = '0;
          end
        end else begin
          confirm_nxt = 1'b1;
          ctimer_nxt  = '0;
        end
      end else if (item.key_code == KEY_HASH) begin
        if (cnt_r >= CNT_FULL) begin
          status = ST_ACCEPT;
        end else begin
          att_nxt = (att_r < ATTEMPT_SAT) ? att_r + 4'd1 : ATTEMPT_SAT;
          cnt_nxt = '0;
          for (int i = 0; i < MAX_DIGITS; i++) store_nxt[i] = '0;
          status = (att_nxt >= max_att_r) ? ST_EXHAUST : ST_RETRY;
        end
      end
      // key codes above hash are no key: nothing changes
    end

    // session end
    if (status == ST_TIMEOUT || status == ST_CANCEL || status == ST_ACCEPT ||
        status == ST_EXHAUST) begin
      active_nxt  = 1'b0;
      confirm_nxt = 1'b0;
      cnt_nxt     = '0;
    end

    shown = (status == ST_ACCEPT) ? 4'(CNT_FULL) : 4'(cnt_nxt);

    result.status         = status;
    result.id_value       = (status == ST_ACCEPT) ? id_acc : '0;
    result.digits_entered = shown[1:0];
    result.confirming     = confirm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      confirm_r <= 1'b0;
      cnt_r     <= '0;
      att_r     <= '0;
      stimer_r  <= '0;
      ctimer_r  <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) store_r[i] <= '0;
    end else if (step) begin
      active_r  <= active_nxt;
      confirm_r <= confirm_nxt;
      cnt_r     <= cnt_nxt;
      att_r     <= att_nxt;
      stimer_r  <= stimer_nxt;
      ctimer_r  <= ctimer_nxt;
      store_r   <= store_nxt;
    end
  end

endmodule

>>> rtl/core/kie_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kie_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module kie_out_stage import kie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       src_valid,
  input  result_t    src,
  output logic       load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [9:0] out_id_value,
  output logic [1:0] out_digits_entered,
  output logic       out_confirming
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  // the register frees up in the same cycle its word is taken
  assign load      = src_valid && (!valid_r || !out_stall);
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= src;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = data_r.status;
  assign out_id_value       = data_r.id_value;
  assign out_digits_entered = data_r.digits_entered;
  assign out_confirming     = data_r.confirming;

endmodule

>>> rtl/core/keypad_id_entry_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_id_entry_controller
// Keypad ID entry session: start, key and tick events in, one status word out.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_func, in_key_code
// out      out  out_valid/out_stall out_status, out_id_value,
//                                  out_digits_entered, out_confirming
// cfg      in   cfg_wr_en          cfg_index, cfg_wdata
//
// One word per cycle sustained while out is not stalled; the result passes from
// the input register through the state update into the result register.
// Reset is synchronous and clears session state; timeout is 60, attempts 3.
// A stall on out holds the result register; in stalls only while the input
// register is full and its word cannot move into the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_id_entry_controller import kie_pkg::*; #(
  parameter int MAX_DIGITS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [9:0] out_id_value,
  output logic [1:0] out_digits_entered,
  output logic       out_confirming,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic    item_valid;
  item_t   item;
  logic    step;
  result_t result;

  kie_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_key_code (in_key_code),
    .adv         (step),
    .item_valid  (item_valid),
    .item        (item)
  );

  kie_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  kie_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .src_valid          (item_valid),
    .src                (result),
    .load               (step),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_id_value       (out_id_value),
    .out_digits_entered (out_digits_entered),
    .out_confirming     (out_confirming)
  );

  // confirm mode only opens on an empty entry and takes no digits
  `KIE_ASSERT_IMP(a_confirm_empty, out_valid && out_confirming, out_digits_entered == 2'd0)
  // an idle result carries no entry and no confirm
  `KIE_ASSERT_IMP(a_idle_clear, out_valid && out_status == ST_IDLE,
                  out_digits_entered == 2'd0 && !out_confirming)
  // accepted shows the full digit count
  `KIE_ASSERT_IMP(a_accept_full, out_valid && out_status == ST_ACCEPT,
                  out_digits_entered == 2'(MAX_DIGITS) && !out_confirming)
  // a word in the input register reaches the output when the output is free
  `KIE_ASSERT_NXT(a_advance, item_valid && !(out_valid && out_stall), out_valid)

endmodule
